// File: rtl/q2e_pkg.sv
package q2e_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int ATAN_IDX_W   = 5;

    // datapath widths
    localparam int QW  = 18;   // quaternion component
    localparam int PW  = 36;   // component product
    localparam int SW  = 38;   // matrix sum before scaling
    localparam int MW  = 30;   // matrix term, Q.24
    localparam int XW  = 34;   // CORDIC x/y
    localparam int AW  = 26;   // angle, 2^-16 degree
    localparam int CW  = 31;   // root magnitude
    localparam int GW  = 30;   // inverse gain

    // pre-rotation stage plus one cell per iteration
    localparam int CORDIC_LAT = CORDIC_STEPS + 1;
    // products, matrix terms, first CORDIC, root scaling, pitch CORDIC, output
    localparam int PIPE_DEPTH = 2 * CORDIC_LAT + 4;

    localparam logic signed [SW-1:0] ONE_Q32     = SW'(64'sd4294967296);
    localparam logic [GW-1:0]        INV_GAIN    = GW'(652032874);
    localparam logic [CW-1:0]        LOCK_LIMIT  = CW'(16777);
    localparam logic signed [AW-1:0] QUARTER     = AW'(90 * 65536);
    localparam logic signed [AW:0]   ANGLE_LIMIT = (AW+1)'(23040);
    localparam logic signed [AW:0]   ROUND_HALF  = (AW+1)'(256);

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } cdata_t;

    function automatic logic signed [AW-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [AW-1:0] v;
        case (idx)
            5'd0:    v = AW'(2949120);
            5'd1:    v = AW'(1740967);
            5'd2:    v = AW'(919879);
            5'd3:    v = AW'(466945);
            5'd4:    v = AW'(234379);
            5'd5:    v = AW'(117304);
            5'd6:    v = AW'(58666);
            5'd7:    v = AW'(29335);
            5'd8:    v = AW'(14668);
            5'd9:    v = AW'(7334);
            5'd10:   v = AW'(3667);
            5'd11:   v = AW'(1833);
            5'd12:   v = AW'(917);
            5'd13:   v = AW'(458);
            5'd14:   v = AW'(229);
            5'd15:   v = AW'(115);
            5'd16:   v = AW'(57);
            5'd17:   v = AW'(29);
            5'd18:   v = AW'(14);
            5'd19:   v = AW'(7);
            5'd20:   v = AW'(4);
            5'd21:   v = AW'(2);
            5'd22:   v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // round to 1/128 degree, halves upward, then clamp to a half turn
    function automatic logic signed [15:0] to_out(input logic signed [AW-1:0] a);
        logic signed [AW:0] t;
        t = $signed({a[AW-1], a}) + ROUND_HALF;
        t = t >>> 9;
        if (t > ANGLE_LIMIT)
        begin
            t = ANGLE_LIMIT;
        end
        else if (t < -ANGLE_LIMIT)
        begin
            t = -ANGLE_LIMIT;
        end
        return t[15:0];
    endfunction

endpackage

// File: rtl/q2e_in_if.sv
interface q2e_in_if import q2e_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// File: rtl/q2e_out_if.sv
interface q2e_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] roll_deg;
    logic signed [15:0] heading_deg;

    modport source (output valid, pitch_deg, roll_deg, heading_deg, input ready);
    modport sink   (input valid, pitch_deg, roll_deg, heading_deg, output ready);
endinterface

// File: rtl/q2e_cell.sv
module q2e_cell import q2e_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [STEP_W-1:0] step,
    input  cdata_t            d,
    output cdata_t            q
);

    cdata_t q_reg;
    cdata_t q_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [AW-1:0] t;

    always_comb
    begin
        dx     = d.y >>> step;
        dy     = d.x >>> step;
        t      = atan_lut(ATAN_IDX_W'(step));
        q_next = d;
        // turn towards the x axis
        if (!d.y[XW-1])
        begin
            q_next.x   = d.x + dx;
            q_next.y   = d.y - dy;
            q_next.ang = d.ang + t;
        end
        else
        begin
            q_next.x   = d.x - dx;
            q_next.y   = d.y + dy;
            q_next.ang = d.ang - t;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: rtl/q2e_cordic.sv
module q2e_cordic import q2e_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    output logic signed [AW-1:0] ang,
    output logic signed [XW-1:0] mag
);

    cdata_t pre_reg;
    cdata_t pre_next;
    cdata_t link [CORDIC_STEPS+1];

    always_comb
    begin
        pre_next.x    = x_in;
        pre_next.y    = y_in;
        pre_next.ang  = '0;
        pre_next.zero = (x_in == '0) && (y_in == '0);
        // bring the left half plane into the right one by a quarter turn
        if (x_in[XW-1])
        begin
            if (!y_in[XW-1])
            begin
                pre_next.x   = y_in;
                pre_next.y   = -x_in;
                pre_next.ang = QUARTER;
            end
            else
            begin
                pre_next.x   = -y_in;
                pre_next.y   = x_in;
                pre_next.ang = -QUARTER;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg <= pre_next;
        end
    end

    assign link[0] = pre_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cell
        q2e_cell u_cell
        (
            .clk  (clk),
            .en   (en),
            .step (STEP_W'(k)),
            .d    (link[k]),
            .q    (link[k+1])
        );
    end

    assign ang = link[CORDIC_STEPS].zero ? '0 : link[CORDIC_STEPS].ang;
    assign mag = link[CORDIC_STEPS].zero ? '0 : link[CORDIC_STEPS].x;

endmodule

// File: rtl/quaternion_to_euler.sv
// Quaternion to ZYX Euler angles. Each request carries one attitude quaternion
// (w, x, y, z, signed Q2.16, taken as given without normalisation) and yields
// pitch, roll and heading in signed 1/128 degree, clamped to +-180 degrees.
// Roll is zero and heading comes from the yaw-roll sum when the pitch cosine
// is 0.001 or less. One request is taken every cycle while the output is not
// stalled. The pipeline holds two CORDIC rows in series (the root feeds the
// pitch arctangent) plus product, matrix, scaling and output stages.
// A stall on the output holds the whole pipeline.
module quaternion_to_euler import q2e_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    q2e_in_if.sink    quat,
    q2e_out_if.source euler
);

    typedef struct packed {
        logic                 lock_n;
        logic                 s_neg;
        logic signed [AW-1:0] head;
        logic signed [AW-1:0] roll;
        logic signed [AW-1:0] gim;
    } side_t;

    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;

    logic signed [PW-1:0] yy_reg, zz_reg, xx_reg, xy_reg, wz_reg;
    logic signed [PW-1:0] yz_reg, wx_reg, xz_reg, wy_reg;

    logic signed [MW-1:0] m00_reg, m10_reg, m11_reg, m12_reg;
    logic signed [MW-1:0] m20_reg, m21_reg, m22_reg;

    logic signed [MW-1:0] s_dly_reg [CORDIC_LAT];
    logic signed [AW-1:0] a_ang, r_ang, g_ang;
    logic signed [XW-1:0] a_mag;
    logic [CW+GW-1:0]     c_prod;

    logic [CW-1:0]        c_reg;
    logic signed [MW-1:0] s_reg;
    logic signed [AW-1:0] a_reg, r_reg, g_reg;

    side_t                side_dly_reg [CORDIC_LAT];
    side_t                side_in;
    side_t                side_out;
    logic signed [AW-1:0] p_ang;

    logic signed [15:0] pitch_reg, roll_reg, head_reg;

    function automatic logic signed [MW-1:0] mterm(
        input logic signed [PW-1:0] a,
        input logic signed [PW-1:0] b,
        input logic                 sub_b,
        input logic                 from_one
    );
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] t;
        s = sub_b ? ($signed({{2{a[PW-1]}}, a}) - $signed({{2{b[PW-1]}}, b}))
                  : ($signed({{2{a[PW-1]}}, a}) + $signed({{2{b[PW-1]}}, b}));
        t = from_one ? (ONE_Q32 - (s <<< 1)) : (s <<< 1);
        return t[SW-1:8];
    endfunction

    assign adv        = !vld_reg[PIPE_DEPTH-1] || euler.ready;
    assign quat.ready = adv;
    assign vld_next   = {vld_reg[PIPE_DEPTH-2:0], quat.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // component products, then rotation-matrix terms in Q.24
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yy_reg <= quat.quat_y * quat.quat_y;
            zz_reg <= quat.quat_z * quat.quat_z;
            xx_reg <= quat.quat_x * quat.quat_x;
            xy_reg <= quat.quat_x * quat.quat_y;
            wz_reg <= quat.quat_w * quat.quat_z;
            yz_reg <= quat.quat_y * quat.quat_z;
            wx_reg <= quat.quat_w * quat.quat_x;
            xz_reg <= quat.quat_x * quat.quat_z;
            wy_reg <= quat.quat_w * quat.quat_y;

            m00_reg <= mterm(yy_reg, zz_reg, 1'b0, 1'b1);
            m10_reg <= mterm(xy_reg, wz_reg, 1'b0, 1'b0);
            m11_reg <= mterm(xx_reg, zz_reg, 1'b0, 1'b1);
            m12_reg <= mterm(yz_reg, wx_reg, 1'b1, 1'b0);
            m20_reg <= mterm(xz_reg, wy_reg, 1'b1, 1'b0);
            m21_reg <= mterm(wx_reg, yz_reg, 1'b0, 1'b0);
            m22_reg <= mterm(xx_reg, yy_reg, 1'b0, 1'b1);
        end
    end

    q2e_cordic u_cordic_head
    (
        .clk   (clk),
        .en    (adv),
        .x_in  (XW'(m00_reg)),
        .y_in  (XW'(m10_reg)),
        .ang   (a_ang),
        .mag   (a_mag)
    );

    q2e_cordic u_cordic_roll
    (
        .clk   (clk),
        .en    (adv),
        .x_in  (XW'(m22_reg)),
        .y_in  (XW'(m21_reg)),
        .ang   (r_ang),
        .mag   ()
    );

    q2e_cordic u_cordic_gim
    (
        .clk   (clk),
        .en    (adv),
        .x_in  (XW'(m11_reg)),
        .y_in  (-XW'(m12_reg)),
        .ang   (g_ang),
        .mag   ()
    );

    // root = CORDIC magnitude times inverse gain, Q.30 dropped
    assign c_prod = (CW+GW)'(a_mag[CW-1:0]) * (CW+GW)'(INV_GAIN);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_dly_reg[0] <= -m20_reg;
            for (int k = 1; k < CORDIC_LAT; k++)
            begin
                s_dly_reg[k] <= s_dly_reg[k-1];
            end
            c_reg <= c_prod[CW+GW-1:GW];
            s_reg <= s_dly_reg[CORDIC_LAT-1];
            a_reg <= a_ang;
            r_reg <= r_ang;
            g_reg <= g_ang;
        end
    end

    q2e_cordic u_cordic_pitch
    (
        .clk   (clk),
        .en    (adv),
        .x_in  (XW'(c_reg)),
        .y_in  (XW'(s_reg)),
        .ang   (p_ang),
        .mag   ()
    );

    always_comb
    begin
        side_in.lock_n = (c_reg > LOCK_LIMIT);
        side_in.s_neg  = s_reg[MW-1];
        side_in.head   = a_reg;
        side_in.roll   = r_reg;
        side_in.gim    = g_reg;
    end

    assign side_out = side_dly_reg[CORDIC_LAT-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_dly_reg[0] <= side_in;
            for (int k = 1; k < CORDIC_LAT; k++)
            begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
            pitch_reg <= to_out(p_ang);
            if (side_out.lock_n)
            begin
                roll_reg <= to_out(side_out.roll);
                head_reg <= to_out(side_out.head);
            end
            else
            begin
                roll_reg <= '0;
                head_reg <= to_out(side_out.s_neg ? side_out.gim : -side_out.gim);
            end
        end
    end

    assign euler.valid       = vld_reg[PIPE_DEPTH-1];
    assign euler.pitch_deg   = pitch_reg;
    assign euler.roll_deg    = roll_reg;
    assign euler.heading_deg = head_reg;

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid && !euler.ready |-> !quat.ready)
        else $error("input taken while output stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid && quat.ready |=> vld_reg[0])
        else $error("accepted request lost at pipeline entry");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid |-> (euler.pitch_deg <= 16'sd23040 && euler.pitch_deg >= -16'sd23040
                      && euler.heading_deg <= 16'sd23040
                      && euler.heading_deg >= -16'sd23040))
        else $error("angle beyond half turn");

endmodule

// File: test/q2e_checker.sv
`timescale 1ns / 100ps

module q2e_checker import q2e_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    q2e_in_if    quat,
    q2e_out_if   euler,
    output int   errors,
    output int   outstanding
);

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] heading;
    } angles_t;

    localparam longint LOCK_Q24     = 16777;
    localparam longint INV_GAIN_Q30 = 652032874;
    localparam longint HALF_TURN    = 23040;

    localparam longint ATAN_STEP [0:31] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    angles_t pending_angles[$];

    // arctangent of (y, x) in 2^-16 degree, gain-scaled magnitude in mag
    function automatic longint vector_angle(input longint xi, input longint yi,
                                            output longint mag);
        longint x;
        longint y;
        longint t;
        longint dx;
        longint dy;
        longint ang;
        x   = xi;
        y   = yi;
        ang = 0;
        mag = 0;
        if (x == 0 && y == 0)
        begin
            return 0;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x   = y;
                y   = -t;
                ang = 90 * 65536;
            end
            else
            begin
                x   = -y;
                y   = t;
                ang = -90 * 65536;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> (i % 32);
            dy = x >>> (i % 32);
            if (y >= 0)
            begin
                x   = x + dx;
                y   = y - dy;
                ang = ang + ATAN_STEP[i % 32];
            end
            else
            begin
                x   = x - dx;
                y   = y + dy;
                ang = ang - ATAN_STEP[i % 32];
            end
        end
        mag = x;
        return ang;
    endfunction

    function automatic logic signed [15:0] to_degrees(input longint a);
        longint v;
        v = (a + 256) >>> 9;
        if (v > HALF_TURN)
        begin
            v = HALF_TURN;
        end
        if (v < -HALF_TURN)
        begin
            v = -HALF_TURN;
        end
        return v[15:0];
    endfunction

    function automatic angles_t euler_angles(input logic signed [QW-1:0] qw,
                                             input logic signed [QW-1:0] qx,
                                             input logic signed [QW-1:0] qy,
                                             input logic signed [QW-1:0] qz);
        longint w, x, y, z;
        longint m00, m10, m11, m12, m20, m21, m22;
        longint one, s, c, mag, pitch, roll, heading, a;
        angles_t r;
        w   = qw;
        x   = qx;
        y   = qy;
        z   = qz;
        one = 64'sd1 << 32;
        m00 = (one - 2 * (y * y + z * z)) >>> 8;
        m10 = (2 * (x * y + w * z)) >>> 8;
        m11 = (one - 2 * (x * x + z * z)) >>> 8;
        m12 = (2 * (y * z - w * x)) >>> 8;
        m20 = (2 * (x * z - w * y)) >>> 8;
        m21 = (2 * (w * x + y * z)) >>> 8;
        m22 = (one - 2 * (x * x + y * y)) >>> 8;
        s = -m20;
        a = vector_angle(m00, m10, mag);
        c = (mag * INV_GAIN_Q30) >>> 30;
        pitch = vector_angle(c, s, mag);
        if (c > LOCK_Q24)
        begin
            roll    = vector_angle(m22, m21, mag);
            heading = vector_angle(m00, m10, mag);
        end
        else
        begin
            // gimbal lock: fold roll into heading
            a       = vector_angle(m11, -m12, mag);
            roll    = 0;
            heading = (s < 0) ? a : -a;
        end
        r.pitch   = to_degrees(pitch);
        r.roll    = to_degrees(roll);
        r.heading = to_degrees(heading);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors      = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin
        angles_t exp_a;
        if (rst_n)
        begin
            if (quat.valid && quat.ready)
            begin
                pending_angles.push_back(euler_angles(quat.quat_w, quat.quat_x,
                                                      quat.quat_y, quat.quat_z));
            end
            if (euler.valid && euler.ready)
            begin
                if (pending_angles.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    exp_a = pending_angles.pop_front();
                    if (euler.pitch_deg !== exp_a.pitch)
                        report_mismatch("pitch", euler.pitch_deg, exp_a.pitch);
                    if (euler.roll_deg !== exp_a.roll)
                        report_mismatch("roll", euler.roll_deg, exp_a.roll);
                    if (euler.heading_deg !== exp_a.heading)
                        report_mismatch("heading", euler.heading_deg, exp_a.heading);
                end
            end
            outstanding <= pending_angles.size();
        end
    end

endmodule

// File: test/tb_quaternion_to_euler.sv
`timescale 1ns / 100ps

module tb_quaternion_to_euler import q2e_pkg::*;;

    localparam int N_RANDOM    = 1080;
    localparam int CYCLE_LIMIT = 300000;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   cycles;
    int   sent;
    int   burst_left;
    bit   holding;

    q2e_in_if  quat ();
    q2e_out_if euler ();

    quaternion_to_euler u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat.sink),
        .euler (euler.source)
    );

    q2e_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .quat        (quat),
        .euler       (euler),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver: random stall pattern, with open stretches and one long hold-off
    initial
    begin
        euler.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holding)
                euler.ready <= 1'b0;
            else if ((cycles / 200) % 3 == 0)
                euler.ready <= 1'b1;
            else
                euler.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    initial
    begin
        holding = 1'b0;
        wait (sent >= 300);
        holding = 1'b1;
        repeat (400) @(posedge clk);
        holding = 1'b0;
    end

    task automatic send_request(input logic signed [QW-1:0] w, input logic signed [QW-1:0] x,
                                input logic signed [QW-1:0] y, input logic signed [QW-1:0] z);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                quat.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        quat.valid  <= 1'b1;
        quat.quat_w <= w;
        quat.quat_x <= x;
        quat.quat_y <= y;
        quat.quat_z <= z;
        @(posedge clk);
        while (!quat.ready)
            @(posedge clk);
        sent++;
    endtask

    // near-unit quaternion, at pitch +90 degrees for a positive sg, with a little noise if noisy
    task automatic send_locked(input bit noisy);
        real t;
        int  p;
        int  q;
        int  sg;
        t  = $urandom_range(0, 62831) / 10000.0;
        p  = $rtoi(46341.0 * $cos(t));
        q  = $rtoi(46341.0 * $sin(t));
        sg = $urandom_range(0, 1) ? 1 : -1;
        if (noisy)
            send_request(QW'(p + $signed($urandom_range(0, 8)) - 4), QW'(-q), QW'(sg * p),
                         QW'(q + $signed($urandom_range(0, 8)) - 4));
        else
            send_request(QW'(p), QW'(-q), QW'(sg * p), QW'(q));
    endtask

    function automatic logic signed [QW-1:0] rand_comp(input int mode);
        if (mode == 0)
            return QW'($urandom);
        return QW'($signed($urandom_range(0, 2 * 65536)) - 65536);
    endfunction

    initial
    begin
        int mode;
        rst_n       = 1'b0;
        quat.valid  = 1'b0;
        quat.quat_w = '0;
        quat.quat_x = '0;
        quat.quat_y = '0;
        quat.quat_z = '0;
        sent        = 0;
        burst_left  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(65536, 0, 0, 0);                 // identity
        send_request(0, 0, 0, 0);                     // all matrix cross terms zero
        send_request(-131072, -131072, -131072, -131072);
        send_request(131071, 131071, 131071, 131071);
        send_request(131071, -131072, 131071, -131072);
        send_request(0, 65536, 0, 0);                 // roll half turn
        send_request(0, 0, 0, 65536);                 // heading on negative x axis
        send_request(0, 0, 65536, 0);
        send_request(46341, 0, 46341, 0);             // pitch up, gimbal lock
        send_request(46341, 0, -46341, 0);            // pitch down
        send_request(32768, 32768, 32768, 32768);
        send_request(32768, -32768, 32768, -32768);
        send_request(0, 131071, 0, 0);                // far from unit length
        send_request(1, -1, 1, -1);
        send_request(46341, 0, 0, 46341);
        send_request(46341, 0, 0, -46341);
        send_request(46341, 46341, 0, 0);
        send_request(0, 46341, 0, 46341);
        send_locked(1'b0);
        send_locked(1'b1);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 3)
                send_request(rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0));
            else if (mode < 7)
                send_request(rand_comp(1), rand_comp(1), rand_comp(1), rand_comp(1));
            else
                send_locked(mode == 9);
        end
        quat.valid <= 1'b0;
        @(posedge clk);

        while (outstanding != 0 || euler.valid)
            @(posedge clk);
        repeat (PIPE_DEPTH + 20) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/q2e_pkg.sv
rtl/q2e_in_if.sv
rtl/q2e_out_if.sv
rtl/q2e_cell.sv
rtl/q2e_cordic.sv
rtl/quaternion_to_euler.sv
test/q2e_checker.sv
test/tb_quaternion_to_euler.sv
